@@ rtl/can_bus_load_monitor_core_macros.svh @@
// Assertion macros used by the monitor's core module.
`ifndef CAN_BUS_LOAD_MONITOR_CORE_MACROS_SVH
`define CAN_BUS_LOAD_MONITOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CBLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`define CBLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define CBLM_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define CBLM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/cblm_pkg.sv @@
package cblm_pkg;

    localparam int WINDOW     = 5;
    localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W      = 32;
    localparam int INTERVAL_W = 16;
    localparam int RATE_W     = 20;
    localparam int DLC_W      = 4;
    localparam int LOAD_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam int SCALE      = 100000;
    localparam int SCALE_W    = 17;
    localparam int WIN_W      = $clog2(WINDOW + 1);
    localparam int PROD_W     = INTERVAL_W + RATE_W;
    localparam int NUM_W      = SUM_W + SCALE_W;
    localparam int DEN_W      = PROD_W + WIN_W;
    localparam int QUOT_W     = LOAD_W;
    localparam int CMP_W      = ((NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W) + 1;
    localparam int DIV_STEPS  = QUOT_W + 1;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);
    localparam logic [RATE_W-1:0]     RATE_RESET     = RATE_W'(500000);

    localparam logic [SUM_W-1:0] STD_FRAME_BITS = SUM_W'(47);
    localparam logic [SUM_W-1:0] EXT_FRAME_BITS = SUM_W'(67);
    localparam logic [DLC_W-1:0] MAX_DATA_BYTES = DLC_W'(8);

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_RATE    = CFG_IDX_W'(1);

    typedef struct packed {
        logic             kind;
        logic [DLC_W-1:0] dlc;
        logic             extended_id;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0]  window_bits;
        logic [LOAD_W-1:0] load_percent;
    } out_item_t;

    typedef struct packed {
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [SUM_W-1:0] wr_data;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCALE,
        ST_START,
        ST_DIVIDE,
        ST_RESULT
    } cblm_state_t;

    function automatic logic [SUM_W-1:0] frame_bits(input logic [DLC_W-1:0] dlc,
                                                    input logic ext);
        logic [DLC_W-1:0] bytes;
        logic [SUM_W-1:0] base;
        bytes = (dlc > MAX_DATA_BYTES) ? MAX_DATA_BYTES : dlc;
        base  = ext ? EXT_FRAME_BITS : STD_FRAME_BITS;
        return base + (SUM_W'(bytes) << 3);
    endfunction

endpackage

@@ rtl/cblm_slot_ram.sv @@
module cblm_slot_ram (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cblm_pkg::ram_req_t             req,
    output logic [cblm_pkg::SUM_W-1:0]     rd_data
);

    logic [cblm_pkg::SUM_W-1:0]  slot_mem [cblm_pkg::WINDOW];
    logic [cblm_pkg::WINDOW-1:0] vld_reg;
    logic                        rd_vld_reg;
    logic [cblm_pkg::SUM_W-1:0]  rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            slot_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= slot_mem[req.rd_addr];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/cblm_divider.sv @@
module cblm_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [cblm_pkg::NUM_W-1:0]      num,
    input  logic [cblm_pkg::DEN_W-1:0]      den,
    output logic                            done,
    output logic [cblm_pkg::QUOT_W-1:0]     quot
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [cblm_pkg::CNT_W-1:0]       cnt_reg;
    logic [cblm_pkg::CMP_W-1:0]       rem_reg;
    logic [cblm_pkg::CMP_W-1:0]       dsh_reg;
    logic [cblm_pkg::QUOT_W:0]        q_reg;
    logic [cblm_pkg::CMP_W:0]         diff;
    logic                             take;

    assign diff = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign take = !diff[cblm_pkg::CMP_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cblm_pkg::CNT_W'(cblm_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // The top quotient bit marks a quotient of 256 or more.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= cblm_pkg::CMP_W'(num);
            dsh_reg <= cblm_pkg::CMP_W'(den) << cblm_pkg::QUOT_W;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[cblm_pkg::CMP_W-1:0] : rem_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[cblm_pkg::QUOT_W-1:0], take};
        end
    end

    assign done = done_reg;
    assign quot = q_reg[cblm_pkg::QUOT_W] ? '1 : q_reg[cblm_pkg::QUOT_W-1:0];

endmodule

@@ rtl/can_bus_load_monitor_core.sv @@
// Channel  Signals                              Direction
// in       in_valid, in_ready, in_data          frame or tick request into the block
// out      out_valid, out_ready, out_data       one result per tick request
// cfg      cfg_valid, cfg_ready, cfg_index/data register write, always ready
//
// A frame request updates the period count as soon as it is taken.
// A tick request walks the update, scale, start, divide and result states, the nine-step
// divider for the load being the longest; no new request is taken until it is back in idle.
// The window slots sit in a memory with a registered read; unwritten slots read as zero.
// All control state clears on rst_n; no clearing pass is needed.
// A finished result waits in the output register while new requests are taken.
`include "can_bus_load_monitor_core_macros.svh"

module can_bus_load_monitor_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cblm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cblm_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cblm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cblm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    cblm_pkg::cblm_state_t                state_reg;
    cblm_pkg::cblm_state_t                state_next;

    logic [cblm_pkg::INTERVAL_W-1:0]      interval_reg;
    logic [cblm_pkg::RATE_W-1:0]          rate_reg;
    logic [cblm_pkg::SUM_W-1:0]           period_bits_reg;
    logic [cblm_pkg::SUM_W-1:0]           closed_reg;
    logic [cblm_pkg::SUM_W-1:0]           sum_reg;
    logic [cblm_pkg::SUM_W-1:0]           sum_next;
    logic [cblm_pkg::PTR_W-1:0]           slot_ptr_reg;
    logic [cblm_pkg::PTR_W-1:0]           slot_ptr_next;
    logic [cblm_pkg::PROD_W-1:0]          prod_reg;
    logic [cblm_pkg::NUM_W-1:0]           num_reg;
    logic [cblm_pkg::DEN_W-1:0]           den_reg;
    logic                                 out_valid_reg;
    cblm_pkg::out_item_t                  out_data_reg;

    cblm_pkg::ram_req_t                   ram_req;
    logic [cblm_pkg::SUM_W-1:0]           ram_rd_data;
    logic                                 div_start;
    logic                                 div_done;
    logic [cblm_pkg::QUOT_W-1:0]          div_quot;

    logic                                 in_accept;
    logic                                 tick_accept;
    logic                                 frame_accept;
    logic                                 upd_en;
    logic                                 scale_en;
    logic                                 out_load;

    assign in_accept    = in_valid && in_ready;
    assign tick_accept  = in_accept && (in_data.kind == cblm_pkg::KIND_TICK);
    assign frame_accept = in_accept && (in_data.kind == cblm_pkg::KIND_FRAME);
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cblm_pkg::ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = cblm_pkg::ST_UPDATE;
                end
            end
            cblm_pkg::ST_UPDATE: state_next = cblm_pkg::ST_SCALE;
            cblm_pkg::ST_SCALE:  state_next = cblm_pkg::ST_START;
            cblm_pkg::ST_START:  state_next = cblm_pkg::ST_DIVIDE;
            cblm_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = cblm_pkg::ST_RESULT;
                end
            end
            cblm_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = cblm_pkg::ST_IDLE;
                end
            end
            default: state_next = cblm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        upd_en          = 1'b0;
        scale_en        = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = slot_ptr_reg;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = slot_ptr_reg;
        ram_req.wr_data = closed_reg;
        unique case (state_reg)
            cblm_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                ram_req.rd_en = tick_accept;
            end
            cblm_pkg::ST_UPDATE:
            begin
                upd_en        = 1'b1;
                ram_req.wr_en = 1'b1;
            end
            cblm_pkg::ST_SCALE:  scale_en  = 1'b1;
            cblm_pkg::ST_START:  div_start = 1'b1;
            cblm_pkg::ST_DIVIDE: ;
            cblm_pkg::ST_RESULT: out_load  = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign sum_next      = sum_reg - ram_rd_data + closed_reg;
    assign slot_ptr_next = (slot_ptr_reg == cblm_pkg::PTR_W'(cblm_pkg::WINDOW - 1)) ?
                           '0 : slot_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cblm_pkg::ST_IDLE;
            interval_reg    <= cblm_pkg::INTERVAL_RESET;
            rate_reg        <= cblm_pkg::RATE_RESET;
            period_bits_reg <= '0;
            sum_reg         <= '0;
            slot_ptr_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cblm_pkg::CFG_INTERVAL_MS:
                        interval_reg <= cfg_data[cblm_pkg::INTERVAL_W-1:0];
                    cblm_pkg::CFG_BIT_RATE:
                        rate_reg <= cfg_data[cblm_pkg::RATE_W-1:0];
                endcase
            end
            if (frame_accept)
            begin
                period_bits_reg <= period_bits_reg +
                                   cblm_pkg::frame_bits(in_data.dlc, in_data.extended_id);
            end
            else if (tick_accept)
            begin
                period_bits_reg <= '0;
            end
            if (upd_en)
            begin
                sum_reg      <= sum_next;
                slot_ptr_reg <= slot_ptr_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            closed_reg <= period_bits_reg;
        end
        if (upd_en)
        begin
            prod_reg <= cblm_pkg::PROD_W'(interval_reg) * cblm_pkg::PROD_W'(rate_reg);
        end
        if (scale_en)
        begin
            num_reg <= cblm_pkg::NUM_W'(sum_reg) * cblm_pkg::NUM_W'(cblm_pkg::SCALE);
            den_reg <= cblm_pkg::DEN_W'(prod_reg) * cblm_pkg::DEN_W'(cblm_pkg::WINDOW);
        end
        if (out_load)
        begin
            out_data_reg.window_bits  <= sum_reg;
            out_data_reg.load_percent <= div_quot;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cblm_slot_ram u_slot_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    cblm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    `CBLM_ASSERT_NEXT(a_tick_closes_period, clk, rst_n, tick_accept,
        (state_reg == cblm_pkg::ST_UPDATE) && (period_bits_reg == '0))
    `CBLM_ASSERT_NOW(a_result_from_sequence, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == cblm_pkg::ST_RESULT))
    `CBLM_ASSERT_NOW(a_slot_ptr_in_range, clk, rst_n, 1'b1,
        slot_ptr_reg <= cblm_pkg::PTR_W'(cblm_pkg::WINDOW - 1))

endmodule
